/* sv/ep2c_pkg.sv */
`timescale 1ns / 1ps

package ep2c_pkg;

    // Width of the shared compare/subtract unit: a shifted partial
    // remainder of the day division stays below 2 * 86400.
    localparam int UNIT_W = 18;

    localparam logic [UNIT_W-1:0] SEC_PER_DAY  = 18'd86400;
    localparam logic [UNIT_W-1:0] SEC_PER_MIN  = 18'd60;
    localparam logic [UNIT_W-1:0] MIN_PER_HOUR = 18'd60;
    localparam logic [UNIT_W-1:0] DAYS_PER_WK  = 18'd7;
    localparam logic [16:0]       EPOCH_WDAY   = 17'd3;
    localparam logic [11:0]       EPOCH_YEAR   = 12'd1970;

    // Last step index of each long division; the division runs one more step
    localparam logic [4:0] DAY_DIV_STEPS  = 5'd31;
    localparam logic [4:0] MIN_DIV_STEPS  = 5'd16;
    localparam logic [4:0] HOUR_DIV_STEPS = 5'd10;
    localparam logic [4:0] WDAY_DIV_STEPS = 5'd16;

    // One calendar breakdown
    typedef struct packed {
        logic [7:0]  year_offset;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [2:0]  weekday;
        logic [10:0] minute_of_day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_cal_rec;

    // Gregorian leap rule; exact for years 1970 through 2225, where the
    // only century years are 2000 (leap), 2100 and 2200 (common).
    function automatic logic is_leap(input logic [7:0] yoff);
        logic [11:0] y;
        y = EPOCH_YEAR + {4'b0000, yoff};
        return (y[1:0] == 2'b00) && (y != 12'd2100) && (y != 12'd2200);
    endfunction

    function automatic logic [8:0] year_len(input logic [7:0] yoff);
        return is_leap(yoff) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* sv/ep2c_cmpsub.sv */
`timescale 1ns / 1ps

module ep2c_cmpsub (
    input  logic [ep2c_pkg::UNIT_W-1:0] i_a,
    input  logic [ep2c_pkg::UNIT_W-1:0] i_b,
    output logic                        o_ge,
    output logic [ep2c_pkg::UNIT_W-1:0] o_diff
);

    logic [ep2c_pkg::UNIT_W:0] w_sub;

    // Subtract with borrow out; no borrow means a >= b
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[ep2c_pkg::UNIT_W];
    assign o_diff = w_sub[ep2c_pkg::UNIT_W-1:0];

endmodule

/* sv/ep2c_core.sv */
`timescale 1ns / 1ps

module ep2c_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_secs,
    input  logic                i_take,
    output logic                o_idle,
    output logic                o_done,
    output ep2c_pkg::t_cal_rec  o_rec
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DIV_DAY = 8'b0000_0010,
        S_DIV_MIN = 8'b0000_0100,
        S_DIV_HR  = 8'b0000_1000,
        S_DIV_WK  = 8'b0001_0000,
        S_YEAR    = 8'b0010_0000,
        S_MONTH   = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [31:0] r_dvd,  n_dvd;
    logic [16:0] r_rem,  n_rem;
    logic [4:0]  r_cnt,  n_cnt;
    logic [15:0] r_days, n_days;
    logic [7:0]  r_yoff, n_yoff;
    logic [3:0]  r_mon,  n_mon;
    logic [5:0]  r_sec,  n_sec;
    logic [5:0]  r_min,  n_min;
    logic [4:0]  r_hour, n_hour;
    logic [10:0] r_mod,  n_mod;
    logic [2:0]  r_wday, n_wday;

    logic [ep2c_pkg::UNIT_W-1:0] w_a, w_b, w_diff;
    logic                        w_ge;
    logic [31:0]                 w_q_next;
    logic [16:0]                 w_rem_next;
    logic                        w_div;

    ep2c_cmpsub u_cmpsub (
        .i_a    (w_a),
        .i_b    (w_b),
        .o_ge   (w_ge),
        .o_diff (w_diff)
    );

    // Select the shared unit operands for the current step
    always_comb begin
        w_div = 1'b1;
        w_b   = ep2c_pkg::SEC_PER_DAY;
        case (r_state)
            S_DIV_DAY: w_b = ep2c_pkg::SEC_PER_DAY;
            S_DIV_MIN: w_b = ep2c_pkg::SEC_PER_MIN;
            S_DIV_HR:  w_b = ep2c_pkg::MIN_PER_HOUR;
            S_DIV_WK:  w_b = ep2c_pkg::DAYS_PER_WK;
            S_YEAR: begin
                w_div = 1'b0;
                w_b   = {9'd0, ep2c_pkg::year_len(r_yoff)};
            end
            S_MONTH: begin
                w_div = 1'b0;
                w_b   = {13'd0, ep2c_pkg::month_len(r_mon, ep2c_pkg::is_leap(r_yoff))};
            end
            default: w_b = ep2c_pkg::SEC_PER_DAY;
        endcase
        w_a = w_div ? {r_rem, r_dvd[31]} : {2'b00, r_days};
    end

    // Restoring long division step: quotient bits shift in at the bottom
    assign w_q_next   = {r_dvd[30:0], w_ge};
    assign w_rem_next = w_ge ? w_diff[16:0] : w_a[16:0];

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_days  = r_days;
        n_yoff  = r_yoff;
        n_mon   = r_mon;
        n_sec   = r_sec;
        n_min   = r_min;
        n_hour  = r_hour;
        n_mod   = r_mod;
        n_wday  = r_wday;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_dvd   = i_secs;
                    n_rem   = '0;
                    n_cnt   = ep2c_pkg::DAY_DIV_STEPS;
                    n_state = S_DIV_DAY;
                end
            end
            S_DIV_DAY: begin
                n_dvd = w_q_next;
                n_rem = w_rem_next;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    // days and second of day; start second-of-day / 60
                    n_days  = w_q_next[15:0];
                    n_dvd   = {w_rem_next, 15'd0};
                    n_rem   = '0;
                    n_cnt   = ep2c_pkg::MIN_DIV_STEPS;
                    n_state = S_DIV_MIN;
                end
            end
            S_DIV_MIN: begin
                n_dvd = w_q_next;
                n_rem = w_rem_next;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_sec   = w_rem_next[5:0];
                    n_mod   = w_q_next[10:0];
                    n_dvd   = {w_q_next[10:0], 21'd0};
                    n_rem   = '0;
                    n_cnt   = ep2c_pkg::HOUR_DIV_STEPS;
                    n_state = S_DIV_HR;
                end
            end
            S_DIV_HR: begin
                n_dvd = w_q_next;
                n_rem = w_rem_next;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_hour  = w_q_next[4:0];
                    n_min   = w_rem_next[5:0];
                    n_dvd   = {({1'b0, r_days} + ep2c_pkg::EPOCH_WDAY), 15'd0};
                    n_rem   = '0;
                    n_cnt   = ep2c_pkg::WDAY_DIV_STEPS;
                    n_state = S_DIV_WK;
                end
            end
            S_DIV_WK: begin
                n_dvd = w_q_next;
                n_rem = w_rem_next;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_wday  = w_rem_next[2:0] + 3'd1;
                    n_yoff  = '0;
                    n_state = S_YEAR;
                end
            end
            S_YEAR: begin
                // Drop whole years while the day count covers one
                if (w_ge) begin
                    n_days = w_diff[15:0];
                    n_yoff = r_yoff + 8'd1;
                end else begin
                    n_mon   = '0;
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (w_ge) begin
                    n_days = w_diff[15:0];
                    n_mon  = r_mon + 4'd1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the result until the output register takes it
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_days <= n_days;
        r_yoff <= n_yoff;
        r_mon  <= n_mon;
        r_sec  <= n_sec;
        r_min  <= n_min;
        r_hour <= n_hour;
        r_mod  <= n_mod;
        r_wday <= n_wday;
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);

    always_comb begin
        o_rec.second        = r_sec;
        o_rec.minute        = r_min;
        o_rec.hour          = r_hour;
        o_rec.minute_of_day = r_mod;
        o_rec.weekday       = r_wday;
        o_rec.day_of_month  = r_days[4:0] + 5'd1;
        o_rec.month         = r_mon + 4'd1;
        o_rec.year_offset   = r_yoff;
    end

endmodule

/* sv/epoch_seconds_to_calendar.sv */
`timescale 1ns / 1ps
// From input transfer to result valid: 77 long division steps on the shared
// subtractor, then one step per whole year of the year offset (0..136) and per
// month of the zero-based month (0..11), each run closed by one more compare step.
// One item at a time: the shared subtractor is busy until the result is taken.
// Reset: synchronous, active low; clears the sequencer and the output valid.
module epoch_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] epoch_seconds
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // [5:0] second, [11:6] minute, [16:12] hour,
                                     // [27:17] minute_of_day, [30:28] weekday,
                                     // [35:31] day_of_month, [39:36] month,
                                     // [47:40] year_offset
);

    logic               w_idle;
    logic               w_done;
    logic               w_take;
    ep2c_pkg::t_cal_rec w_rec;
    logic               r_m_valid;
    logic [47:0]        r_m_data;

    assign w_take = ~r_m_valid | i_m_tready;

    ep2c_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_s_tvalid & w_idle),
        .i_secs  (i_s_tdata),
        .i_take  (w_take),
        .o_idle  (w_idle),
        .o_done  (w_done),
        .o_rec   (w_rec)
    );

    assign o_s_tready = w_idle;

    // Load the output register when it is free or being emptied, drop valid after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_done && w_take) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_take) begin
            r_m_data <= {w_rec.year_offset, w_rec.month, w_rec.day_of_month,
                         w_rec.weekday, w_rec.minute_of_day, w_rec.hour,
                         w_rec.minute, w_rec.second};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule
